// ===== sv/rdf_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the
// run-length delta frame decoder. No dependencies.
package rdf_pkg;

    // Frame store geometry.
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int REM_W       = $clog2(STORE_DEPTH + 1);
    localparam int RUN_W       = REM_W + 1;

    // Field widths.
    localparam int KIND_W     = 2;
    localparam int POS_W      = 10;
    localparam int DIM_W      = 11;
    localparam int CODE_W     = 32;
    localparam int RADDR_W    = 20;
    localparam int PIX_W      = 32;
    localparam int LEFT_W     = 21;
    localparam int DELTA_BITS = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CHK_W      = ((STORE_AW > RADDR_W) ? STORE_AW : RADDR_W) + 1;

    // Slave-side tdata layout, lowest bits first.
    localparam int LEFT_X_LSB   = 0;
    localparam int TOP_Y_LSB    = LEFT_X_LSB + POS_W;
    localparam int RIGHT_X_LSB  = TOP_Y_LSB + POS_W;
    localparam int BOTTOM_Y_LSB = RIGHT_X_LSB + DIM_W;
    localparam int CODE_LSB     = BOTTOM_Y_LSB + DIM_W;
    localparam int RADDR_LSB    = CODE_LSB + CODE_W;
    localparam int S_USED_W     = RADDR_LSB + RADDR_W;
    localparam int S_TDATA_W    = ((S_USED_W + 7) / 8) * 8;

    // Master-side tdata layout: pixel_value, then pixels_left.
    localparam int M_USED_W  = PIX_W + LEFT_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_RECT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RUN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
    localparam logic [DIM_W-1:0]     DIM_RESET        = 11'd1024;

    // Run code and pixel constants.
    localparam logic [7:0]       LONG_CODE  = 8'he0;
    localparam logic [PIX_W-1:0] ALPHA_MASK = 32'hff000000;

    typedef struct packed {
        logic clear_step;
        logic take_item;
        logic rect_clamp;
        logic rect_mult;
        logic run_setup;
        logic run_read;
        logic run_write;
        logic pix_read;
        logic finish;
    } rdf_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic run_empty;
        logic run_last;
        logic out_busy;
    } rdf_status_t;

endpackage

// ===== sv/rdf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module rdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/rdf_ctrl.sv =====
// Sequencing state machine of the frame decoder: store clear, item dispatch,
// per-pixel read-modify-write steps and result hand-off. Depends on rdf_pkg.
module rdf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           in_kind,
    input  rdf_pkg::rdf_status_t status,
    output rdf_pkg::rdf_cmd_t    cmd,
    output logic                 in_ready
);
    import rdf_pkg::*;

    typedef enum logic [8:0] {
        ST_CLEAR      = 9'b000000001,
        ST_IDLE       = 9'b000000010,
        ST_RECT_CLAMP = 9'b000000100,
        ST_RECT_MULT  = 9'b000001000,
        ST_RUN_SETUP  = 9'b000010000,
        ST_RUN_READ   = 9'b000100000,
        ST_RUN_WRITE  = 9'b001000000,
        ST_PIX_READ   = 9'b010000000,
        ST_FINISH     = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    case (in_kind)
                        KIND_RECT: state_next = ST_RECT_CLAMP;
                        KIND_RUN:  state_next = ST_RUN_SETUP;
                        KIND_READ: state_next = ST_PIX_READ;
                        default:   state_next = ST_FINISH;
                    endcase
                end
            end
            ST_RECT_CLAMP:
            begin
                cmd.rect_clamp = 1'b1;
                state_next     = ST_RECT_MULT;
            end
            ST_RECT_MULT:
            begin
                cmd.rect_mult = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_RUN_SETUP:
            begin
                cmd.run_setup = 1'b1;
                state_next    = ST_RUN_READ;
            end
            ST_RUN_READ:
            begin
                if (status.run_empty)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.run_read = 1'b1;
                    state_next   = ST_RUN_WRITE;
                end
            end
            ST_RUN_WRITE:
            begin
                cmd.run_write = 1'b1;
                state_next    = status.run_last ? ST_FINISH : ST_RUN_READ;
            end
            ST_PIX_READ:
            begin
                cmd.pix_read = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== sv/rdf_datapath.sv =====
// Datapath of the frame decoder: configuration registers, rectangle and
// cursor registers, the frame store and the result register.
// Depends on rdf_pkg and rdf_ram.
module rdf_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rdf_pkg::rdf_cmd_t                   cmd,
    output rdf_pkg::rdf_status_t                status,
    input  logic                                cfg_write,
    input  logic [rdf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rdf_pkg::DIM_W-1:0]           cfg_data,
    input  logic [rdf_pkg::KIND_W-1:0]          kind,
    input  logic [rdf_pkg::POS_W-1:0]           left_x,
    input  logic [rdf_pkg::POS_W-1:0]           top_y,
    input  logic [rdf_pkg::DIM_W-1:0]           right_x,
    input  logic [rdf_pkg::DIM_W-1:0]           bottom_y,
    input  logic [rdf_pkg::CODE_W-1:0]          code_word,
    input  logic [rdf_pkg::RADDR_W-1:0]         read_address,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [rdf_pkg::PIX_W-1:0]           pixel_value,
    output logic                                rect_done,
    output logic                                overrun,
    output logic [rdf_pkg::LEFT_W-1:0]          pixels_left
);
    import rdf_pkg::*;

    // Configuration.
    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;
    logic [DIM_W-1:0] fw;
    logic [DIM_W-1:0] fh;

    // Item registers.
    logic [KIND_W-1:0]  kind_reg;
    logic [POS_W-1:0]   left_in_reg;
    logic [POS_W-1:0]   top_in_reg;
    logic [DIM_W-1:0]   right_in_reg;
    logic [DIM_W-1:0]   bottom_in_reg;
    logic [CODE_W-1:0]  code_reg;
    logic [RADDR_W-1:0] raddr_reg;

    // Rectangle setup.
    logic [DIM_W-1:0] right_c;
    logic [DIM_W-1:0] bottom_c;
    logic [DIM_W-1:0] span_w_reg;
    logic [DIM_W-1:0] span_h_reg;
    logic [DIM_W-1:0] bot_m1_reg;
    logic             empty_reg;

    // Decode state.
    logic [POS_W-1:0]    cursor_reg;
    logic [STORE_AW-1:0] row_base_reg;
    logic [POS_W-1:0]    rect_left_reg;
    logic [DIM_W-1:0]    rect_right_reg;
    logic [REM_W-1:0]    remaining_reg;
    logic [REM_W-1:0]    run_cnt_reg;
    logic                over_reg;

    // Run decode.
    logic [7:0]       len_code;
    logic [5:0]       len_exp;
    logic [RUN_W-1:0] run_len;
    logic             run_over;
    logic [REM_W-1:0] run_n;

    // Addressing.
    logic [CHK_W-1:0]    pix_addr;
    logic                pix_in_range;
    logic [CHK_W-1:0]    raddr_chk;
    logic                raddr_in_range;
    logic [DIM_W-1:0]    cursor_inc;
    logic [STORE_AW-1:0] clear_cnt_reg;

    // Memory ports.
    logic                 ram_we;
    logic [STORE_AW-1:0]  ram_waddr;
    logic [PIX_W-1:0]     ram_wdata;
    logic                 ram_re;
    logic [STORE_AW-1:0]  ram_raddr;
    logic [PIX_W-1:0]     ram_rdata;
    logic [DELTA_BITS-1:0] delta_sum;

    // Result register.
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_pixel_reg;
    logic             out_done_reg;
    logic             out_over_reg;
    logic [LEFT_W-1:0] out_left_reg;

    // Effective frame size: zero acts as one, large values saturate.
    always_comb
    begin
        if (frame_width_reg == '0)
            fw = DIM_W'(1);
        else if (int'(frame_width_reg) > MAX_WIDTH)
            fw = DIM_W'(MAX_WIDTH);
        else
            fw = frame_width_reg;
        if (frame_height_reg == '0)
            fh = DIM_W'(1);
        else if (int'(frame_height_reg) > MAX_HEIGHT)
            fh = DIM_W'(MAX_HEIGHT);
        else
            fh = frame_height_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DIM_RESET;
            frame_height_reg <= DIM_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            kind_reg      <= kind;
            left_in_reg   <= left_x;
            top_in_reg    <= top_y;
            right_in_reg  <= right_x;
            bottom_in_reg <= bottom_y;
            code_reg      <= code_word;
            raddr_reg     <= read_address;
        end
    end

    assign right_c  = (right_in_reg > fw) ? fw : right_in_reg;
    assign bottom_c = (bottom_in_reg > fh) ? fh : bottom_in_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rect_clamp)
        begin
            span_w_reg <= right_c - DIM_W'(left_in_reg);
            span_h_reg <= bottom_c - DIM_W'(top_in_reg);
            bot_m1_reg <= bottom_c - DIM_W'(1);
            empty_reg  <= (right_c <= DIM_W'(left_in_reg)) ||
                          (bottom_c <= DIM_W'(top_in_reg));
        end
    end

    // Run length: short codes are code+1, long codes a power of two that
    // saturates once it no longer fits in RUN_W bits.
    always_comb
    begin
        len_code = code_reg[CODE_W-1 -: 8];
        len_exp  = 6'(len_code - LONG_CODE) + 6'd7;
        if (len_code < LONG_CODE)
            run_len = RUN_W'(len_code) + RUN_W'(1);
        else if (int'(len_exp) >= RUN_W)
            run_len = '1;
        else
            run_len = RUN_W'(1) << len_exp;
        run_over = run_len > RUN_W'(remaining_reg);
        run_n    = run_over ? remaining_reg : run_len[REM_W-1:0];
    end

    assign pix_addr       = CHK_W'(row_base_reg) + CHK_W'(cursor_reg);
    assign pix_in_range   = pix_addr < CHK_W'(STORE_DEPTH);
    assign raddr_chk      = CHK_W'(raddr_reg);
    assign raddr_in_range = raddr_chk < CHK_W'(STORE_DEPTH);
    assign cursor_inc     = DIM_W'(cursor_reg) + DIM_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg     <= '0;
            row_base_reg   <= '0;
            rect_left_reg  <= '0;
            rect_right_reg <= '0;
            remaining_reg  <= '0;
            run_cnt_reg    <= '0;
            over_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.rect_clamp)
            begin
                rect_left_reg  <= left_in_reg;
                rect_right_reg <= right_c;
                cursor_reg     <= left_in_reg;
            end
            if (cmd.rect_mult)
            begin
                if (empty_reg)
                begin
                    remaining_reg <= '0;
                    row_base_reg  <= '0;
                end
                else
                begin
                    remaining_reg <= REM_W'(span_w_reg * span_h_reg);
                    row_base_reg  <= STORE_AW'(bot_m1_reg * fw);
                end
            end
            if (cmd.run_setup)
            begin
                run_cnt_reg   <= run_n;
                over_reg      <= run_over;
                remaining_reg <= remaining_reg - run_n;
            end
            if (cmd.run_write)
            begin
                run_cnt_reg <= run_cnt_reg - REM_W'(1);
                if (cursor_inc >= rect_right_reg)
                begin
                    // End of a rectangle row: back to the left edge, one row up.
                    cursor_reg   <= rect_left_reg;
                    row_base_reg <= (row_base_reg >= STORE_AW'(fw)) ?
                                    row_base_reg - STORE_AW'(fw) : '0;
                end
                else
                begin
                    cursor_reg <= cursor_inc[POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clear_cnt_reg <= clear_cnt_reg + STORE_AW'(1);
        end
    end

    assign delta_sum = ram_rdata[DELTA_BITS-1:0] + code_reg[DELTA_BITS-1:0];
    assign ram_we    = cmd.clear_step || (cmd.run_write && pix_in_range);
    assign ram_waddr = cmd.clear_step ? clear_cnt_reg : pix_addr[STORE_AW-1:0];
    assign ram_wdata = cmd.clear_step ? '0 : (ALPHA_MASK | PIX_W'(delta_sum));
    assign ram_re    = cmd.run_read || cmd.pix_read;
    assign ram_raddr = cmd.run_read ? pix_addr[STORE_AW-1:0] : raddr_chk[STORE_AW-1:0];

    rdf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_pixel_reg <= ((kind_reg == KIND_READ) && raddr_in_range) ? ram_rdata : '0;
            out_done_reg  <= (remaining_reg == '0);
            out_over_reg  <= (kind_reg == KIND_RUN) && over_reg;
            out_left_reg  <= LEFT_W'(remaining_reg);
        end
    end

    assign status.clear_last = (clear_cnt_reg == STORE_AW'(STORE_DEPTH - 1));
    assign status.run_empty  = (run_cnt_reg == '0);
    assign status.run_last   = (run_cnt_reg == REM_W'(1));
    assign status.out_busy   = out_valid_reg && !out_ready;

    assign out_valid   = out_valid_reg;
    assign pixel_value = out_pixel_reg;
    assign rect_done   = out_done_reg;
    assign overrun     = out_over_reg;
    assign pixels_left = out_left_reg;

endmodule

// ===== sv/rle_delta_rect_frame_decoder.sv =====
// Top level of the run-length delta frame decoder: port packing, the
// controller and the datapath. Depends on rdf_pkg, rdf_ctrl, rdf_datapath.
//
// Usage. Items arrive on the s_ channel: s_tuser is the item kind (start
// rectangle, run code word, read pixel) and s_tdata carries the rectangle,
// code word and read address fields. Every item gives exactly one result on
// the m_ channel: m_tdata holds the pixel read (zero for other kinds) and
// the pixels still left in the rectangle, m_tlast is set when the rectangle
// is fully covered, and m_tuser flags a run that was clamped as an overrun.
// Frame width and height are written through the cfg_ port while no item
// is in flight; that port is always ready.
// Sequence. Items are handled one at a time. A read goes through a read
// step, a rectangle through a clamp step and then a step for the two
// multiplies, and a run word through a setup step and then a read followed
// by a write for each pixel written on the single frame store; each item
// ends in a finish step that registers the result.
// s_tready rises again as the result is registered.
// Reset. After rst_n rises the frame store is cleared to zero, one entry per
// cycle, over all 1048576 entries; s_tready stays low during that pass.
// Stall. The result sits in an output register, so the next item is taken
// while it waits; that item then holds in its last step until m_tready
// frees the register.
module rle_delta_rect_frame_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rdf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rdf_pkg::DIM_W-1:0]         cfg_data,
    // Input items.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata fields from bit 0: left_x[10], top_y[10], right_x[11],
    // bottom_y[11], code_word[32], read_address[20], zero padding.
    input  logic [rdf_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: kind[2].
    input  logic [rdf_pkg::KIND_W-1:0]        s_tuser,
    // Results.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata fields from bit 0: pixel_value[32], pixels_left[21], padding.
    output logic [rdf_pkg::M_TDATA_W-1:0]     m_tdata,
    // m_tlast: rect_done.
    output logic                              m_tlast,
    // m_tuser: overrun[1].
    output logic                              m_tuser
);
    import rdf_pkg::*;

    rdf_cmd_t          cmd;
    rdf_status_t       status;
    logic [PIX_W-1:0]  pixel_value;
    logic [LEFT_W-1:0] pixels_left;

    assign cfg_ready = 1'b1;

    rdf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .status   (status),
        .cmd      (cmd),
        .in_ready (s_tready)
    );

    rdf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_write    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .kind         (s_tuser),
        .left_x       (s_tdata[LEFT_X_LSB +: POS_W]),
        .top_y        (s_tdata[TOP_Y_LSB +: POS_W]),
        .right_x      (s_tdata[RIGHT_X_LSB +: DIM_W]),
        .bottom_y     (s_tdata[BOTTOM_Y_LSB +: DIM_W]),
        .code_word    (s_tdata[CODE_LSB +: CODE_W]),
        .read_address (s_tdata[RADDR_LSB +: RADDR_W]),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .pixel_value  (pixel_value),
        .rect_done    (m_tlast),
        .overrun      (m_tuser),
        .pixels_left  (pixels_left)
    );

    assign m_tdata = M_TDATA_W'({pixels_left, pixel_value});

`ifndef SYNTHESIS
    // No item is taken while the store is still being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> !s_tready)
        else $error("item accepted during frame store clear");

    // Items are processed one at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted back to back");

    // The done flag agrees with the pixel count it reports.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[PIX_W +: LEFT_W] == '0)))
        else $error("rect_done disagrees with pixels_left");

    // A clamped run always exhausts the rectangle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("overrun reported with pixels still left");
`endif

endmodule

// ===== bench/rdf_decode_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the run-length delta frame decoder: keeps its own copy of
// the frame store and the rectangle cursor, predicts one result per item and
// compares every m_ transfer against it. Depends on rdf_pkg.
module rdf_decode_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [rdf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rdf_pkg::DIM_W-1:0]      cfg_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [rdf_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [rdf_pkg::KIND_W-1:0]     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [rdf_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           m_tlast,
    input  logic                           m_tuser,
    output int                             mismatch_count,
    output int                             results_owed
);
    import rdf_pkg::*;

    typedef struct {
        logic [PIX_W-1:0]  pixel;
        logic              done;
        logic              over;
        logic [LEFT_W-1:0] left;
    } decoded_t;

    bit   [PIX_W-1:0]    frame_copy [STORE_DEPTH];
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [POS_W-1:0]    col_at;
    logic [STORE_AW-1:0] row_base;
    logic [POS_W-1:0]    rect_lo;
    logic [DIM_W-1:0]    rect_hi;
    logic [LEFT_W-1:0]   left_count;
    decoded_t            decoded_q [$];

    // Zero selects one pixel, anything above the frame maximum selects that maximum.
    function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned cap);
        if (v == 0)
            return 1;
        return (v > cap) ? cap : 32'(v);
    endfunction

    function automatic decoded_t decode_item(input logic [KIND_W-1:0] kind,
                                             input logic [S_TDATA_W-1:0] data);
        decoded_t              r;
        int unsigned           fw;
        int unsigned           fh;
        int unsigned           lo;
        int unsigned           hi;
        int unsigned           tp;
        int unsigned           bot;
        int unsigned           addr;
        int unsigned           nxt;
        int unsigned           n;
        longint unsigned       run;
        logic [CODE_W-1:0]     word;
        logic [7:0]            len_code;
        logic [DELTA_BITS-1:0] sum;
        r.pixel = '0;
        r.over  = 1'b0;
        fw = eff_dim(width_reg, MAX_WIDTH);
        fh = eff_dim(height_reg, MAX_HEIGHT);
        case (kind)
            KIND_RECT:
            begin
                lo  = 32'(data[LEFT_X_LSB +: POS_W]);
                tp  = 32'(data[TOP_Y_LSB +: POS_W]);
                hi  = 32'(data[RIGHT_X_LSB +: DIM_W]);
                bot = 32'(data[BOTTOM_Y_LSB +: DIM_W]);
                if (hi > fw)
                    hi = fw;
                if (bot > fh)
                    bot = fh;
                rect_lo = POS_W'(lo);
                rect_hi = DIM_W'(hi);
                col_at  = POS_W'(lo);
                if (hi <= lo || bot <= tp)
                begin
                    left_count = '0;
                    row_base   = '0;
                end
                else
                begin
                    left_count = LEFT_W'((hi - lo) * (bot - tp));
                    row_base   = STORE_AW'((bot - 1) * fw);
                end
            end
            KIND_RUN:
            begin
                word     = data[CODE_LSB +: CODE_W];
                len_code = word[CODE_W-1 -: 8];
                if (len_code < LONG_CODE)
                    run = 64'(len_code) + 64'd1;
                else
                    run = 64'd1 << (len_code - LONG_CODE + 7);
                if (run > 64'(left_count))
                begin
                    r.over = 1'b1;
                    run    = 64'(left_count);
                end
                n = 32'(run);
                repeat (n)
                begin
                    addr = 32'(row_base) + 32'(col_at);
                    if (addr < STORE_DEPTH)
                    begin
                        sum = frame_copy[addr][DELTA_BITS-1:0] + word[DELTA_BITS-1:0];
                        frame_copy[addr] = ALPHA_MASK | PIX_W'(sum);
                    end
                    nxt = 32'(col_at) + 1;
                    if (nxt >= 32'(rect_hi))
                    begin
                        col_at   = rect_lo;
                        row_base = (32'(row_base) >= fw) ? STORE_AW'(32'(row_base) - fw) : '0;
                    end
                    else
                        col_at = POS_W'(nxt);
                end
                left_count = left_count - LEFT_W'(n);
            end
            KIND_READ:
            begin
                addr = 32'(data[RADDR_LSB +: RADDR_W]);
                if (addr < STORE_DEPTH)
                    r.pixel = frame_copy[addr];
            end
            default:
            begin
            end
        endcase
        r.done = (left_count == '0);
        r.left = left_count;
        return r;
    endfunction

    // Every mismatch is printed on one line and counted.
    task automatic flag_mismatch(input string what, input logic [PIX_W-1:0] got,
                                 input logic [PIX_W-1:0] want);
        $display("%0t ns: %s: got %h, predicted %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result();
        decoded_t want;
        if (decoded_q.size() == 0)
        begin
            flag_mismatch("result with no item waiting", m_tdata[0 +: PIX_W], '0);
            return;
        end
        want = decoded_q.pop_front();
        if (m_tdata[0 +: PIX_W] !== want.pixel)
            flag_mismatch("pixel_value", m_tdata[0 +: PIX_W], want.pixel);
        if (m_tdata[PIX_W +: LEFT_W] !== want.left)
            flag_mismatch("pixels_left", PIX_W'(m_tdata[PIX_W +: LEFT_W]), PIX_W'(want.left));
        if (m_tlast !== want.done)
            flag_mismatch("rect_done", PIX_W'(m_tlast), PIX_W'(want.done));
        if (m_tuser !== want.over)
            flag_mismatch("overrun", PIX_W'(m_tuser), PIX_W'(want.over));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (frame_copy[i])
                frame_copy[i] = '0;
            width_reg      = DIM_RESET;
            height_reg     = DIM_RESET;
            col_at         = '0;
            row_base       = '0;
            rect_lo        = '0;
            rect_hi        = '0;
            left_count     = '0;
            mismatch_count = 0;
            decoded_q.delete();
            results_owed   = 0;
        end
        else
        begin
            // The result leaving now always belongs to an older item, so it is
            // compared before the item taken at this edge is predicted.
            if (m_tvalid && m_tready)
                check_result();
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                    width_reg = cfg_data;
                else if (cfg_index == REG_FRAME_HEIGHT)
                    height_reg = cfg_data;
            end
            if (s_tvalid && s_tready)
                decoded_q.push_back(decode_item(s_tuser, s_tdata));
            results_owed = decoded_q.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Top of the run-length delta frame decoder testbench: clock, reset, stimulus
// and verdict. Depends on rdf_pkg, rle_delta_rect_frame_decoder and
// rdf_decode_checker.
module tb;
    import rdf_pkg::*;

    localparam int CLK_PERIOD = 12;
    // The stop time leaves a wide margin over the frame store clear after
    // reset, the items, their stalls and their pixel writes.
    localparam longint STOP_CYCLES = 8_000_000;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
    logic [DIM_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [KIND_W-1:0]    s_tuser   = KIND_RECT;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    int          mismatch_count;
    int          results_owed;
    int          items_sent = 0;
    // Random gaps on the input and stalls on the output are on while set.
    bit          idling     = 1'b0;
    // Effective frame size, used only to aim rectangles and reads.
    int unsigned width_now  = MAX_WIDTH;
    int unsigned height_now = MAX_HEIGHT;

    rle_delta_rect_frame_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    rdf_decode_checker decode_watch (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard stop in case the block hangs or a result never arrives.
    initial
    begin
        #(STOP_CYCLES * CLK_PERIOD);
        $display("CHECK FAILED");
        $finish;
    end

    // Output side: m_tready drops for random bursts while idling is on, and
    // is held high otherwise. All changes are made at the falling edge so the
    // block sees them settled at the next rising edge.
    initial
    begin : sink_side
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if (idling && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(0, 17);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Random contents for every field of an item, padding bits held at zero.
    // The fields that matter for the item kind are overwritten by the caller.
    function automatic logic [S_TDATA_W-1:0] filler();
        logic [S_TDATA_W-1:0] d;
        d = {$urandom, $urandom, $urandom};
        d[S_TDATA_W-1:S_USED_W] = '0;
        return d;
    endfunction

    // Presents one item and returns after the rising edge of its transfer.
    // s_tvalid is left high so that back-to-back items leave no gap on the input.
    task automatic put_item(input logic [KIND_W-1:0] kind, input logic [S_TDATA_W-1:0] d);
        @(negedge clk);
        if (idling && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (kind != KIND_UNUSED)
            items_sent++;
    endtask

    task automatic send_rect(input int unsigned l, input int unsigned t,
                             input int unsigned r, input int unsigned b);
        logic [S_TDATA_W-1:0] d;
        d = filler();
        d[LEFT_X_LSB +: POS_W]   = POS_W'(l);
        d[TOP_Y_LSB +: POS_W]    = POS_W'(t);
        d[RIGHT_X_LSB +: DIM_W]  = DIM_W'(r);
        d[BOTTOM_Y_LSB +: DIM_W] = DIM_W'(b);
        put_item(KIND_RECT, d);
    endtask

    task automatic send_run(input logic [CODE_W-1:0] word);
        logic [S_TDATA_W-1:0] d;
        d = filler();
        d[CODE_LSB +: CODE_W] = word;
        put_item(KIND_RUN, d);
    endtask

    task automatic send_read(input int unsigned addr);
        logic [S_TDATA_W-1:0] d;
        d = filler();
        d[RADDR_LSB +: RADDR_W] = RADDR_W'(addr);
        put_item(KIND_READ, d);
    endtask

    // Reads near the given corner of a rectangle, or anywhere in the store.
    task automatic probe(input int unsigned l, input int unsigned t);
        int unsigned row;
        int unsigned col;
        row = t + $urandom_range(0, 7);
        col = l + $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0)
            send_read($urandom_range(0, STORE_DEPTH - 1));
        else
            send_read(row * width_now + col);
    endtask

    // Drops s_tvalid, waits until every predicted result has been taken, then
    // lets the block sit for the given pause.
    task automatic settle(input int pause);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (pause) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Frame size changes happen only with nothing in flight. A rectangle may
    // still be half decoded across the change; that is intended.
    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned w_eff, input int unsigned h_eff);
        settle(8);
        write_reg(REG_FRAME_WIDTH, DIM_W'(w));
        write_reg(REG_FRAME_HEIGHT, DIM_W'(h));
        width_now  = w_eff;
        height_now = h_eff;
    endtask

    // Pixels along one axis of a rectangle after clamping to the frame.
    function automatic int unsigned span(input int unsigned lo, input int unsigned hi,
                                         input int unsigned lim);
        if (hi > lim)
            hi = lim;
        return (hi > lo) ? hi - lo : 0;
    endfunction

    // One damaged rectangle followed by run words that mostly cover it
    // exactly, with reads mixed in. Now and then the rectangle is abandoned,
    // a run overshoots, or a stray run arrives once it is complete.
    task automatic fill_rect();
        int unsigned pick;
        int unsigned l;
        int unsigned t;
        int unsigned r;
        int unsigned b;
        int unsigned budget;
        int unsigned run_len;
        int unsigned k;
        logic [7:0]  len_code;
        pick = $urandom_range(0, 19);
        l = $urandom_range(0, width_now - 1);
        t = $urandom_range(0, height_now - 1);
        r = l + ((pick == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12));
        b = t + ((pick == 1) ? $urandom_range(1, 16) : $urandom_range(1, 8));
        if (pick == 2)
        begin
            // One row with a random right edge: wide, clamped or empty.
            l = $urandom_range(0, MAX_WIDTH - 1);
            r = $urandom_range(0, 2047);
            b = t + 1;
        end
        else if (pick == 3)
        begin
            // One column with a random bottom edge.
            t = $urandom_range(0, MAX_HEIGHT - 1);
            b = $urandom_range(0, 2047);
            r = l + 1;
        end
        else if (pick == 4)
            r = l;
        send_rect(l, t, r, b);
        budget = span(l, r, width_now) * span(t, b, height_now);
        while (budget > 0)
        begin
            pick = $urandom_range(0, 29);
            if (pick < 5)
                probe(l, t);
            else if (pick == 5)
                return;
            else if (pick == 6)
            begin
                send_run({8'($urandom_range(LONG_CODE, 8'hff)), 24'($urandom)});
                budget = 0;
            end
            else
            begin
                if (budget >= 128 && pick < 10)
                begin
                    k = 0;
                    while ((128 << (k + 1)) <= budget)
                        k++;
                    len_code = LONG_CODE + 8'($urandom_range(0, k));
                    run_len  = 128 << (len_code - LONG_CODE);
                end
                else
                begin
                    run_len  = $urandom_range(1, (pick < 12) ? 224 : 16);
                    if (run_len > budget)
                        run_len = budget;
                    len_code = 8'(run_len - 1);
                end
                send_run({len_code, 24'($urandom)});
                budget -= run_len;
            end
        end
        repeat ($urandom_range(0, 2))
            probe(l, t);
        if ($urandom_range(0, 9) == 0)
            send_run($urandom);
    endtask

    task automatic random_traffic(input int quota);
        int goal;
        goal = items_sent + quota;
        while (items_sent < goal)
            fill_rect();
    endtask

    initial
    begin
        idling = 1'b1;
        // Reset is held low from the start and released at a falling edge. The
        // block then clears its frame store before s_tready rises; the first
        // transfer simply waits for that.
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed items at the reset frame size of 1024 by 1024.
        send_read(0);
        // A run before any rectangle writes nothing and flags an overrun.
        send_run(32'h00ffffff);
        // Small rectangle: two short runs, then a long code that is clamped.
        send_rect(0, 0, 4, 2);
        send_run(32'h02ffffff);
        send_run(32'h01000001);
        send_run(32'he0123456);
        send_read(MAX_WIDTH);
        // Edges past the frame are clamped, leaving only the last pixel.
        send_rect(1023, 1023, 2047, 2047);
        send_run(32'h00abcdef);
        send_read(STORE_DEPTH - 1);
        // Empty rectangle, then the unused item kind.
        send_rect(5, 0, 5, 3);
        put_item(KIND_UNUSED, filler());
        // One full row covered exactly by the 1024-pixel code.
        send_rect(0, 700, 1024, 701);
        send_run(32'he3000101);
        send_read(700 * MAX_WIDTH + 1023);
        // The longest code against a 200-pixel rectangle.
        send_rect(10, 10, 20, 30);
        send_run(32'hff7f7f7f);
        // A rectangle abandoned halfway for a new one.
        send_rect(2, 2, 6, 6);
        send_run(32'h03000010);
        send_rect(100, 100, 104, 102);
        send_run(32'h07fedcba);
        // Ten pixels into a 32-pixel rectangle, then the row stride shrinks
        // to 5 before the rest of it is decoded.
        send_rect(0, 0, 8, 4);
        send_run(32'h09000003);
        set_geometry(5, MAX_HEIGHT, 5, MAX_HEIGHT);
        send_run(32'he0000007);
        send_read(2 * MAX_WIDTH + 2);

        // Random phases over a range of frame sizes, the extremes included.
        random_traffic(100);
        set_geometry(2047, 2047, MAX_WIDTH, MAX_HEIGHT);
        random_traffic(300);
        set_geometry(0, 0, 1, 1);
        random_traffic(100);
        set_geometry(1, MAX_HEIGHT, 1, MAX_HEIGHT);
        random_traffic(150);
        begin : small_frame
            int unsigned w;
            int unsigned h;
            w = $urandom_range(2, 64);
            h = $urandom_range(2, 64);
            set_geometry(w, h, w, h);
        end
        random_traffic(350);
        begin : any_frame
            int unsigned w;
            int unsigned h;
            w = $urandom_range(1, MAX_WIDTH);
            h = $urandom_range(1, MAX_HEIGHT);
            set_geometry(w, h, w, h);
        end
        random_traffic(350);
        // Last part at full size with both sides running flat out.
        set_geometry(MAX_WIDTH, MAX_HEIGHT, MAX_WIDTH, MAX_HEIGHT);
        idling = 1'b0;
        random_traffic(450);

        settle(16);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
